// File: design/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared types, widths and codes of the buffer binding table.
// ----------------------------------------------------------------------------
package bbt_pkg;

  // Default number of table entries
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // Field widths of one request and one response word
  localparam int unsigned COMMON_W = 8;
  localparam int unsigned PACKET_W = 16;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KEY_W    = COMMON_W + PACKET_W + DIR_W;
  localparam int unsigned ENTRY_W  = KEY_W + ID_W;

  // Request operation codes
  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_INQUIRE  = 1'b1
  } op_e;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch the accepted request, restart the scan
    logic issue;    // read the entry at the scan pointer, advance it
    logic capture;  // record the matching entry
    logic emit;     // load the response register, append on a good register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;         // compared entry matches
    logic all_issued;  // every valid entry has been read
    logic cmp_vld;     // an entry is in the compare stage
    logic slot_free;   // response register can take a word
  } sts_t;

endpackage

// File: design/bbt_req_if.sv
// ----------------------------------------------------------------------------
// bbt_req_if
// Request channel of the buffer binding table: valid/ready and one word.
// ----------------------------------------------------------------------------
interface bbt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [bbt_pkg::COMMON_W-1:0]  common_kind;
  logic [bbt_pkg::PACKET_W-1:0]  packet_kind;
  logic [bbt_pkg::DIR_W-1:0]     direction;
  logic [bbt_pkg::ID_W-1:0]      new_id;

  modport source (
    output valid, operation, common_kind, packet_kind, direction, new_id,
    input  ready
  );

  modport sink (
    input  valid, operation, common_kind, packet_kind, direction, new_id,
    output ready
  );
endinterface

// File: design/bbt_rsp_if.sv
// ----------------------------------------------------------------------------
// bbt_rsp_if
// Response channel of the buffer binding table: valid/ready and one word.
// ----------------------------------------------------------------------------
interface bbt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbt_pkg::STATUS_W-1:0]  status;
  logic [bbt_pkg::ID_W-1:0]      found_id;

  modport source (
    output valid, status, found_id,
    input  ready
  );

  modport sink (
    input  valid, status, found_id,
    output ready
  );
endinterface

// File: design/buffer_binding_table.sv
// ----------------------------------------------------------------------------
// buffer_binding_table
// Append-only table binding a (common kind, packet kind, direction) key
// to a 16-bit buffer id.
// ----------------------------------------------------------------------------
// One request word at a time: a register word appends a binding unless its
// id is already bound (duplicate) or the table is full; an inquire word
// returns the id of the oldest entry with an equal key, or not found.
// Entry 0 is bound from reset to the all-zero key and id 0. Each word gives
// exactly one response word. A scan reads one entry per cycle through the
// single read port of the entry memory and stops at the first match, or
// when every valid entry is read without one; it reads at most the fill
// count of entries (up to TABLE_ENTRIES). The response is then loaded into
// the response register once that register is free. A new request is taken
// once the previous response is loaded, even while that response still
// waits.
// ----------------------------------------------------------------------------
module buffer_binding_table #(
  parameter int unsigned TABLE_ENTRIES = bbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbt_req_if.sink   req_i,
  bbt_rsp_if.source rsp_o
);

  bbt_pkg::cmd_t cmd;
  bbt_pkg::sts_t sts;

  // Sequencer
  bbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table storage and compare
  bbt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (req_i.operation),
    .common_kind_i (req_i.common_kind),
    .packet_kind_i (req_i.packet_kind),
    .direction_i   (req_i.direction),
    .new_id_i      (req_i.new_id),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .found_id_o    (rsp_o.found_id)
  );

endmodule

// File: design/bbt_datapath.sv
// ----------------------------------------------------------------------------
// bbt_datapath
// Entry memory, fill count, scan pointer, compare stage and response register.
// ----------------------------------------------------------------------------
module bbt_datapath #(
  parameter int unsigned TABLE_ENTRIES = bbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbt_pkg::cmd_t                 cmd_i,
  output bbt_pkg::sts_t                 sts_o,
  input  logic                          operation_i,
  input  logic [bbt_pkg::COMMON_W-1:0]  common_kind_i,
  input  logic [bbt_pkg::PACKET_W-1:0]  packet_kind_i,
  input  logic [bbt_pkg::DIR_W-1:0]     direction_i,
  input  logic [bbt_pkg::ID_W-1:0]      new_id_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [bbt_pkg::STATUS_W-1:0]  status_o,
  output logic [bbt_pkg::ID_W-1:0]      found_id_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned KEY_W = bbt_pkg::KEY_W;
  localparam int unsigned ID_W  = bbt_pkg::ID_W;

  // Request word
  bbt_pkg::op_e                   op_q;
  logic [KEY_W-1:0]               key_q;
  logic [ID_W-1:0]                id_q;

  // Table state
  logic [bbt_pkg::ENTRY_W-1:0]    mem [TABLE_ENTRIES];
  logic [CNT_W-1:0]               count_q;
  logic [CNT_W-1:0]               scan_q;

  // Compare stage
  logic                           cmp_vld_q;
  logic                           cmp_zero_q;
  logic [bbt_pkg::ENTRY_W-1:0]    rd_data_q;
  logic [bbt_pkg::ENTRY_W-1:0]    entry;
  logic                           match;

  // Scan result
  logic                           hit_q;
  logic [ID_W-1:0]                found_q;

  // Response register
  logic                           out_vld_q;
  logic [bbt_pkg::STATUS_W-1:0]   out_status_q;
  logic [ID_W-1:0]                out_id_q;
  bbt_pkg::status_e               status_d;
  logic [ID_W-1:0]                out_id_d;

  logic                           full;
  logic                           wr_en;

  // Entry 0 is never written and always reads as all zero
  assign entry = cmp_zero_q ? '0 : rd_data_q;

  // Inquire matches on the key, register matches on the id
  always_comb begin
    if (op_q == bbt_pkg::OP_INQUIRE) begin
      match = (entry[bbt_pkg::ENTRY_W-1:ID_W] == key_q);
    end else begin
      match = (entry[ID_W-1:0] == id_q);
    end
  end

  assign full  = (count_q == CNT_W'(TABLE_ENTRIES));
  assign wr_en = cmd_i.emit && (op_q == bbt_pkg::OP_REGISTER) && !hit_q && !full;

  // Pick the response word
  always_comb begin
    out_id_d = '0;
    if (op_q == bbt_pkg::OP_INQUIRE) begin
      if (hit_q) begin
        status_d = bbt_pkg::ST_OK;
        out_id_d = found_q;
      end else begin
        status_d = bbt_pkg::ST_NOT_FOUND;
      end
    end else if (hit_q) begin
      status_d = bbt_pkg::ST_DUPLICATE;
    end else if (full) begin
      status_d = bbt_pkg::ST_FULL;
    end else begin
      status_d = bbt_pkg::ST_OK;
    end
  end

  // Status back to the controller
  assign sts_o.hit        = cmp_vld_q && match;
  assign sts_o.all_issued = (scan_q == count_q);
  assign sts_o.cmp_vld    = cmp_vld_q;
  assign sts_o.slot_free  = !out_vld_q || rsp_ready_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CNT_W'(1);
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        if (cmd_i.capture) begin
          hit_q <= 1'b1;
        end
      end
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= bbt_pkg::op_e'(operation_i);
      key_q <= {common_kind_i, packet_kind_i, direction_i};
      id_q  <= new_id_i;
    end
    if (cmd_i.issue) begin
      cmp_zero_q <= (scan_q == '0);
    end
    if (cmd_i.capture) begin
      found_q <= entry[ID_W-1:0];
    end
    if (cmd_i.emit) begin
      out_status_q <= status_d;
      out_id_q     <= out_id_d;
    end
  end

  // Entry memory: append at the fill count, read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IDX_W-1:0]] <= {key_q, id_q};
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[scan_q[IDX_W-1:0]];
    end
  end

  assign rsp_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign found_id_o  = out_id_q;

  // Fill count stays between one entry and a full table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(TABLE_ENTRIES)))
    else $error("fill count out of range");

  // Reads only touch valid entries
  a_issue_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (scan_q < count_q))
    else $error("scan read beyond valid entries");

  // Appends only happen with room left and raise the count by one
  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("append did not advance the fill count");

  // A response word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_vld_q || rsp_ready_i))
    else $error("response overwritten");

endmodule

// File: design/bbt_ctrl.sv
// ----------------------------------------------------------------------------
// bbt_ctrl
// Sequencer of the buffer binding table: accept, scan, respond.
// ----------------------------------------------------------------------------
module bbt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bbt_pkg::sts_t  sts_i,
  output bbt_pkg::cmd_t  cmd_o
);

  bbt_pkg::ctrl_state_e state_q;
  bbt_pkg::ctrl_state_e state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      bbt_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bbt_pkg::S_SCAN;
        end
      end
      bbt_pkg::S_SCAN: begin
        // Stop reading at the first match or past the last valid entry
        cmd_o.capture = sts_i.hit;
        cmd_o.issue   = !sts_i.hit && !sts_i.all_issued;
        if (sts_i.hit || (sts_i.all_issued && !sts_i.cmp_vld)) begin
          state_d = bbt_pkg::S_DONE;
        end
      end
      bbt_pkg::S_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = bbt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bbt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
